// ===== rtl/core/q2y_pkg.sv =====
// shared types, widths and the arctangent table of the quaternion heading pipeline
package q2y_pkg;

  // component width, signed q1.15
  localparam int QW = 16;
  // product width of two components
  localparam int PW = 2 * QW;
  // width of num and den, 30 fraction bits, magnitude up to 2^32
  localparam int NUM_W = 34;
  // cordic datapath width, covers the cordic gain on a 2^32.5 vector
  localparam int DW = 36;
  // angle accumulator, one full turn is 2^32
  localparam int ACC_W = 32;
  // output angle width
  localparam int HW = 16;
  // entries of the arctangent table
  localparam int ATAN_ENTRIES = 24;
  // default number of cordic iterations
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [ACC_W-1:0] ANG_ZERO = 32'h0000_0000;
  localparam logic [ACC_W-1:0] ANG_PLUS_HALF_PI = 32'h4000_0000;
  localparam logic [ACC_W-1:0] ANG_MINUS_HALF_PI = 32'hC000_0000;
  // half an output lsb, for round to nearest
  localparam logic [ACC_W-1:0] ANG_ROUND = 32'h0000_8000;
  // 1.0 with 30 fraction bits
  localparam logic signed [NUM_W-1:0] ONE_Q30 = {{(NUM_W-31){1'b0}}, 1'b1, 30'b0};

  // vector and angle carried down the cordic chain
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [ACC_W-1:0]     ang;
    logic                 zero;
  } q2y_vec_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  function automatic logic [ACC_W-1:0] atan_turn(input int idx);
    logic [ACC_W-1:0] v;
    case (idx)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/q2y_front.sv =====
// front end: products, atan2 arguments and quadrant pre-rotation over three stages
module q2y_front
  import q2y_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           en,
  input  logic                 in_valid,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  output logic [2:0]           valid,
  output q2y_vec_t             vec
);

  logic signed [PW-1:0]    p_wz;
  logic signed [PW-1:0]    p_xy;
  logic signed [PW-1:0]    p_yy;
  logic signed [PW-1:0]    p_zz;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] den;
  logic signed [NUM_W-1:0] num_next;
  logic signed [NUM_W-1:0] den_next;
  logic signed [DW-1:0]    num_ext;
  logic signed [DW-1:0]    den_ext;
  q2y_vec_t                vec_next;

  // valid bits follow the words
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      if (en[1]) valid[1] <= valid[0];
      if (en[2]) valid[2] <= valid[1];
    end
  end

  // stage one: the four products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // stage two: num = 2(wz+xy), den = 1 - 2(y^2+z^2)
  always_comb begin
    num_next = ({{(NUM_W-PW){p_wz[PW-1]}}, p_wz} + {{(NUM_W-PW){p_xy[PW-1]}}, p_xy}) <<< 1;
    den_next = ONE_Q30
             - (({{(NUM_W-PW){p_yy[PW-1]}}, p_yy} + {{(NUM_W-PW){p_zz[PW-1]}}, p_zz}) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num <= num_next;
      den <= den_next;
    end
  end

  // stage three: turn a left half-plane vector by a quarter turn
  always_comb begin
    num_ext = {{(DW-NUM_W){num[NUM_W-1]}}, num};
    den_ext = {{(DW-NUM_W){den[NUM_W-1]}}, den};
    vec_next.zero = (num == '0) && (den == '0);
    if (den[NUM_W-1]) begin
      if (!num[NUM_W-1]) begin
        vec_next.x   = num_ext;
        vec_next.y   = -den_ext;
        vec_next.ang = ANG_PLUS_HALF_PI;
      end else begin
        vec_next.x   = -num_ext;
        vec_next.y   = den_ext;
        vec_next.ang = ANG_MINUS_HALF_PI;
      end
    end else begin
      vec_next.x   = den_ext;
      vec_next.y   = num_ext;
      vec_next.ang = ANG_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) vec <= vec_next;
  end

endmodule

// ===== rtl/core/q2y_cordic_stage.sv =====
// one registered vectoring-mode cordic iteration
module q2y_cordic_stage
  import q2y_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  q2y_vec_t in_vec,
  output logic     out_valid,
  output q2y_vec_t out_vec
);

  localparam logic [ACC_W-1:0] ATAN_STEP = atan_turn(STEP);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  q2y_vec_t             vec_next;

  // rotate towards the x axis using the old x and y
  always_comb begin
    dx = in_vec.y >>> STEP;
    dy = in_vec.x >>> STEP;
    vec_next.zero = in_vec.zero;
    if (!in_vec.y[DW-1]) begin
      vec_next.x   = in_vec.x + dx;
      vec_next.y   = in_vec.y - dy;
      vec_next.ang = in_vec.ang + ATAN_STEP;
    end else begin
      vec_next.x   = in_vec.x - dx;
      vec_next.y   = in_vec.y + dy;
      vec_next.ang = in_vec.ang - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_vec <= vec_next;
  end

endmodule

// ===== rtl/core/quaternion_to_yaw.sv =====
// quaternion to heading angle converter, top level
//
// input word: one orientation quaternion w, x, y, z in signed q1.15.
// output word: heading = atan2(2(wz+xy), 1-2(y^2+z^2)) as a signed 16-bit
// binary angle, -32768..32767 covering -pi..pi; a zero argument pair gives 0.
// both channels are valid/ready streams; a word moves when tvalid and tready
// are both high at a rising edge.
// the default is 16 cordic iterations; steps above 24 are limited to 24.
// throughput: one word per cycle while the receiver does not stall, set by
// the fully unrolled pipeline of three front stages, one stage per cordic
// iteration and an output register.
// each stage holds its own valid bit and moves when it is empty or the stage
// after it moves, so bubbles close up and input is taken while a finished
// result waits; a stall from the receiver holds words in place, none lost.
// reset (synchronous, active high) empties the pipeline; nothing is kept
// between words.
module quaternion_to_yaw
  import q2y_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  input  logic [63:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // heading [15:0]
  output logic [15:0]   m_axis_tdata
);

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  // front stages, cordic stages, output register
  localparam int NT = 3 + NSTEPS + 1;

  logic [NT-1:0]     v_all;
  logic [NT-1:0]     en;
  logic [2:0]        v_front;
  logic [NSTEPS:0]   v_cordic;
  q2y_vec_t          vec_chain [0:NSTEPS];
  logic              out_valid;
  logic [HW-1:0]     heading;
  logic [HW-1:0]     heading_next;
  logic [ACC_W-1:0]  ang_rounded;

  // stage advance chain: a stage moves when empty or when its successor moves
  assign v_all = {out_valid, v_cordic[NSTEPS:1], v_front};
  assign en[NT-1] = !v_all[NT-1] || m_axis_tready;

  genvar k;
  generate
    for (k = 0; k < NT - 1; k++) begin : g_en
      assign en[k] = !v_all[k] || en[k+1];
    end
  endgenerate

  assign s_axis_tready = en[0];

  q2y_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en[2:0]),
    .in_valid (s_axis_tvalid),
    .quat_w   (s_axis_tdata[15:0]),
    .quat_x   (s_axis_tdata[31:16]),
    .quat_y   (s_axis_tdata[47:32]),
    .quat_z   (s_axis_tdata[63:48]),
    .valid    (v_front),
    .vec      (vec_chain[0])
  );

  assign v_cordic[0] = v_front[2];

  // one stage per cordic iteration
  generate
    for (k = 0; k < NSTEPS; k++) begin : g_cordic
      q2y_cordic_stage #(
        .STEP (k)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (en[3+k]),
        .in_valid  (v_cordic[k]),
        .in_vec    (vec_chain[k]),
        .out_valid (v_cordic[k+1]),
        .out_vec   (vec_chain[k+1])
      );
    end
  endgenerate

  // round the turn accumulator to 16 bits, zero pair forced to 0
  always_comb begin
    ang_rounded  = vec_chain[NSTEPS].ang + ANG_ROUND;
    heading_next = vec_chain[NSTEPS].zero ? '0 : ang_rounded[ACC_W-1 -: HW];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[NT-1]) begin
      out_valid <= v_cordic[NSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NT-1]) heading <= heading_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = heading;

endmodule

// ===== sim/quaternion_to_yaw_chk.sv =====
// checker for the heading converter: predicts each heading and compares it with the output stream
`timescale 1ns / 100ps

module quaternion_to_yaw_chk
  import q2y_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  input  logic            s_axis_tready,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  input  logic [63:0]     s_axis_tdata,
  input  logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // heading [15:0]
  input  logic [HW-1:0]   m_axis_tdata,
  output int              errors,
  output int              pending
);

  // atan(2^-i) in 2^-32 turn, rounded to nearest
  localparam logic [ACC_W-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct {
    logic [63:0]   quat;
    logic [HW-1:0] heading;
  } heading_exp_t;

  heading_exp_t heading_q[$];
  int accepted_n = 0;
  int received_n = 0;
  int fail_n = 0;

  assign errors  = fail_n;
  assign pending = accepted_n - received_n;

  // heading of one quaternion word: exact arguments, then vectoring cordic
  function automatic logic [HW-1:0] yaw_of(input logic [63:0] quat);
    longint qw, qx, qy, qz, num, den, cx, cy, dx, dy;
    logic [ACC_W-1:0] acc;
    qw  = longint'($signed(quat[15:0]));
    qx  = longint'($signed(quat[31:16]));
    qy  = longint'($signed(quat[47:32]));
    qz  = longint'($signed(quat[63:48]));
    num = 2 * (qw * qz + qx * qy);
    den = (longint'(1) <<< 30) - 2 * (qy * qy + qz * qz);
    if (num == 0 && den == 0) begin
      return '0;
    end
    // left half plane: pre-rotate by a quarter turn
    if (den < 0) begin
      if (num >= 0) begin
        cx  = num;
        cy  = -den;
        acc = ANG_PLUS_HALF_PI;
      end else begin
        cx  = -num;
        cy  = den;
        acc = ANG_MINUS_HALF_PI;
      end
    end else begin
      cx  = den;
      cy  = num;
      acc = ANG_ZERO;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        acc = acc + ATAN_TURN[i];
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        acc = acc - ATAN_TURN[i];
      end
    end
    acc = acc + ANG_ROUND;
    return acc[ACC_W-1:ACC_W-HW];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] quat,
                                 input logic [HW-1:0] want, input logic [HW-1:0] got);
    $display("%0t: %s, quat %h: heading expected %0d got %0d",
             $time, what, quat, $signed(want), $signed(got));
    fail_n++;
  endtask

  // queue a prediction per input word, compare each output word with the oldest
  always @(posedge clk) begin
    heading_exp_t head;
    heading_exp_t entry;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        entry.quat    = s_axis_tdata;
        entry.heading = yaw_of(s_axis_tdata);
        heading_q     = {heading_q, entry};
        accepted_n <= accepted_n + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (heading_q.size() == 0) begin
          report_mismatch("output word with no input pending", '0, '0, m_axis_tdata);
        end else begin
          head = heading_q.pop_front();
          received_n <= received_n + 1;
          if (m_axis_tdata !== head.heading) begin
            report_mismatch("heading mismatch", head.quat, head.heading, m_axis_tdata);
          end
        end
      end
    end
  end

endmodule

// ===== sim/quaternion_to_yaw_tb.sv =====
// testbench top: drives quaternion words into the heading converter and gives the verdict
`timescale 1ns / 100ps

module quaternion_to_yaw_tb;
  import q2y_pkg::*;

  localparam int STEPS        = CORDIC_STEPS_DEF;
  localparam int LATENCY      = (STEPS > ATAN_ENTRIES ? ATAN_ENTRIES : STEPS) + 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_WORDS = 680;

  logic          clk = 1'b0;
  logic          rst;
  logic          s_valid;
  logic          s_ready;
  logic [63:0]   s_data;
  logic          m_valid;
  logic          m_ready;
  logic [HW-1:0] m_data;
  int            errors;
  int            pending;
  int            idle_cycles = 0;
  bit            idle_on = 1'b1;
  bit            hold_off = 1'b0;

  quaternion_to_yaw #(
    .CORDIC_STEPS (STEPS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  quaternion_to_yaw_chk #(
    .CORDIC_STEPS (STEPS)
  ) i_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .errors        (errors),
    .pending       (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("quaternion_to_yaw verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_ready = 1'b1;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        m_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [63:0] quat_word(input int w, input int x, input int y, input int z);
    return {z[15:0], y[15:0], x[15:0], w[15:0]};
  endfunction

  function automatic int pick_in(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // random quaternion: half unit length, plus raw, tiny, near half turn and zero-argument
  function automatic logic [63:0] pick_quat();
    real a, b, c, d, n, s;
    int  w, z;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        a = $itor(pick_in(-32767, 32767));
        b = $itor(pick_in(-32767, 32767));
        c = $itor(pick_in(-32767, 32767));
        d = $itor(pick_in(-32767, 32767));
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) begin
          return quat_word(32767, 0, 0, 0);
        end
        s = 32767.0 / n;
        return quat_word($rtoi(a * s), $rtoi(b * s), $rtoi(c * s), $rtoi(d * s));
      end
      5, 6: return {$urandom, $urandom};
      7: return quat_word(pick_in(-8, 8), pick_in(-8, 8), pick_in(-8, 8), pick_in(-8, 8));
      8: begin
        // yaw close to a half turn, either side of the wrap
        z = pick_in(32000, 32767);
        if ($urandom_range(0, 1) == 1) begin
          z = -z - 1;
        end
        return quat_word(pick_in(-300, 300), pick_in(-300, 300), pick_in(-300, 300), z);
      end
      default: begin
        // y^2 + z^2 = 0.5 and wz + xy = 0: both arguments zero
        w = pick_in(-32767, 32767);
        z = ($urandom_range(0, 1) == 1) ? 16384 : -16384;
        if ($urandom_range(0, 1) == 1) begin
          return quat_word(w, -w, z, z);
        end
        return quat_word(w, w, -z, z);
      end
    endcase
  endfunction

  // offer one word, with an optional gap first, and wait for it to be taken
  task automatic put_word(input logic [63:0] word);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= word;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst     = 1'b1;
    s_valid = 1'b0;
    s_data  = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners: extremes, identity, axis turns, half-turn wrap, zero argument pair
    put_word(quat_word(0, 0, 0, 0));
    put_word(quat_word(32767, 0, 0, 0));
    put_word(quat_word(-32768, 0, 0, 0));
    put_word(quat_word(0, -32768, 0, 0));
    put_word(quat_word(0, 0, -32768, 0));
    put_word(quat_word(0, 0, 0, -32768));
    put_word(quat_word(0, 0, 0, 32767));
    put_word(quat_word(0, 0, 32767, 0));
    put_word(quat_word(-32768, -32768, -32768, -32768));
    put_word(quat_word(32767, 32767, 32767, 32767));
    put_word(quat_word(-32768, 32767, -32768, 32767));
    put_word(quat_word(32767, -32768, 32767, -32768));
    put_word(quat_word(23170, 0, 0, 23170));
    put_word(quat_word(23170, 0, 0, -23170));
    put_word(quat_word(1000, 0, 0, 32767));
    put_word(quat_word(-1000, 0, 0, 32767));
    put_word(quat_word(1, -1, 16384, 16384));
    put_word(quat_word(0, 0, 16384, -16384));
    put_word(quat_word(5, 5, -16384, 16384));
    put_word(quat_word(0, 1, 1, 0));
    put_word(quat_word(1, 0, 0, -1));
    put_word(quat_word(0, 0, 0, 1));

    repeat (RANDOM_WORDS) put_word(pick_quat());

    // receiver holds off long enough for the pipeline to back up
    hold_off = 1'b1;
    repeat (60) put_word(pick_quat());

    // sender waits for every heading to come out
    drain();

    repeat (RANDOM_WORDS) put_word(pick_quat());

    // full rate to the end
    idle_on = 1'b0;
    repeat (120) put_word(pick_quat());

    drain();
    repeat (2 * LATENCY) @(negedge clk);
    if (errors == 0) begin
      $display("quaternion_to_yaw verification clean");
    end else begin
      $display("quaternion_to_yaw verification failed");
    end
    $finish;
  end

endmodule
